/* rtl/ocl_pkg.sv */
// ocl_pkg: shared types and codes for the ordered card list engine
// request codes, status codes and the packed card format; no dependencies
package ocl_pkg;

    localparam int CARD_W    = 6;
    localparam int REQ_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int LEN_OUT_W = 7;

    typedef logic [CARD_W-1:0]   card_t;
    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam req_t REQ_ADD_FRONT = 3'd0;
    localparam req_t REQ_ADD_BACK  = 3'd1;
    localparam req_t REQ_FIND      = 3'd2;
    localparam req_t REQ_POP_FRONT = 3'd3;
    localparam req_t REQ_REMOVE    = 3'd4;
    localparam req_t REQ_CLEAR     = 3'd5;

    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_MISS = 2'd1;
    localparam status_t ST_FULL = 2'd2;

endpackage

/* rtl/ocl_node_ram.sv */
// ocl_node_ram: simple dual-port node store, one write and one registered read
// depends on nothing; used for the card and link fields of the node memory
module ocl_node_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ordered_card_list_engine.sv */
// ordered_card_list_engine: linked card list held in node memories with a free list
// depends on ocl_pkg and ocl_node_ram
// One transaction is taken when start is high and busy is low; its result appears
// on status and list_length, marked by done high for exactly one cycle, and the receiver
// cannot hold it off. A transaction needing no memory access (clear, add to a full
// list, pop/find/remove on an empty list, unused codes) gives its result the cycle
// after acceptance. Add writes the node in S_ADD_WR, and add at back on a non-empty list
// then links it to the old tail in S_ADD_LINK; pop frees the head in S_POP_WR. Find and
// remove walk the list one node per cycle through the single read port of the link
// memory; remove on a match then frees the node in S_REM_FREE.
// busy falls in the cycle done is shown, so the next transaction may start then.
module ordered_card_list_engine
    import ocl_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [3:0]           card_num,
    input  logic [1:0]           card_suit,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [LEN_OUT_W-1:0] list_length
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ADD_WR   = 3'd1;
    localparam logic [2:0] S_ADD_LINK = 3'd2;
    localparam logic [2:0] S_POP_WR   = 3'd3;
    localparam logic [2:0] S_WALK     = 3'd4;
    localparam logic [2:0] S_REM_FREE = 3'd5;

    logic [2:0]        state_reg, state_next;
    req_t              req_reg, req_next;
    card_t             card_reg, card_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [SLOT_W-1:0] free_reg, free_next;
    logic [CNT_W-1:0]  fresh_reg, fresh_next;
    logic [CNT_W-1:0]  length_reg, length_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [SLOT_W-1:0] prev_reg, prev_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              done_reg, done_next;
    status_t           status_reg, status_next;

    logic              card_we;
    logic [SLOT_W-1:0] card_waddr;
    card_t             card_wdata;
    card_t             card_rdata;
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr;
    logic [SLOT_W-1:0] link_wdata;
    logic [SLOT_W-1:0] link_rdata;
    logic [SLOT_W-1:0] raddr;

    logic [CNT_W-1:0]  idx_inc;
    logic              use_free;
    logic [SLOT_W-1:0] new_slot;
    logic [CNT_W+LEN_OUT_W-1:0] len_ext;

    ocl_node_ram #(
        .WIDTH (CARD_W),
        .DEPTH (CAPACITY)
    ) u_card_ram (
        .clk   (clk),
        .we    (card_we),
        .waddr (card_waddr),
        .wdata (card_wdata),
        .raddr (raddr),
        .rdata (card_rdata)
    );

    ocl_node_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (raddr),
        .rdata (link_rdata)
    );

    assign idx_inc  = idx_reg + 1'b1;
    assign use_free = (fresh_reg > length_reg);
    assign new_slot = use_free ? free_reg : fresh_reg[SLOT_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        card_next   = card_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        free_next   = free_reg;
        fresh_next  = fresh_reg;
        length_next = length_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        card_we     = 1'b0;
        card_waddr  = new_slot;
        card_wdata  = card_reg;
        link_we     = 1'b0;
        link_waddr  = new_slot;
        link_wdata  = '0;
        raddr       = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                raddr = (req_type inside {REQ_ADD_FRONT, REQ_ADD_BACK})
                        ? free_reg : head_reg;
                if (start)
                begin
                    req_next  = req_type;
                    card_next = {card_num, card_suit};
                    cur_next  = head_reg;
                    prev_next = '0;
                    idx_next  = '0;
                    case (req_type)
                        REQ_ADD_FRONT, REQ_ADD_BACK:
                        begin
                            if (length_reg == CAP_CNT)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_ADD_WR;
                            end
                        end
                        REQ_FIND, REQ_REMOVE, REQ_POP_FRONT:
                        begin
                            if (length_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_MISS;
                            end
                            else if (req_type == REQ_POP_FRONT)
                            begin
                                state_next = S_POP_WR;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            head_next   = '0;
                            tail_next   = '0;
                            free_next   = '0;
                            fresh_next  = '0;
                            length_next = '0;
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_MISS;
                        end
                    endcase
                end
            end

            S_ADD_WR:
            begin
                card_we    = 1'b1;
                link_we    = 1'b1;
                link_wdata = (req_reg == REQ_ADD_FRONT && length_reg != '0) ? head_reg : '0;
                if (use_free)
                begin
                    free_next = link_rdata;
                end
                else
                begin
                    fresh_next = fresh_reg + 1'b1;
                end
                cur_next = new_slot;
                if (length_reg == '0)
                begin
                    head_next   = new_slot;
                    tail_next   = new_slot;
                    length_next = length_reg + 1'b1;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
                else if (req_reg == REQ_ADD_FRONT)
                begin
                    head_next   = new_slot;
                    length_next = length_reg + 1'b1;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_ADD_LINK;
                end
            end

            S_ADD_LINK:
            begin
                link_we     = 1'b1;
                link_waddr  = tail_reg;
                link_wdata  = cur_reg;
                tail_next   = cur_reg;
                length_next = length_reg + 1'b1;
                done_next   = 1'b1;
                status_next = ST_OK;
                state_next  = S_IDLE;
            end

            S_POP_WR:
            begin
                link_we     = 1'b1;
                link_waddr  = head_reg;
                link_wdata  = free_reg;
                free_next   = head_reg;
                head_next   = link_rdata;
                length_next = length_reg - 1'b1;
                done_next   = 1'b1;
                status_next = ST_OK;
                state_next  = S_IDLE;
            end

            S_WALK:
            begin
                if (card_rdata == card_reg)
                begin
                    if (req_reg == REQ_FIND)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        if (idx_reg == '0)
                        begin
                            head_next = link_rdata;
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = prev_reg;
                            link_wdata = link_rdata;
                        end
                        if (idx_inc == length_reg)
                        begin
                            tail_next = prev_reg;
                        end
                        state_next = S_REM_FREE;
                    end
                end
                else if (idx_inc == length_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_MISS;
                    state_next  = S_IDLE;
                end
                else
                begin
                    raddr     = link_rdata;
                    prev_next = cur_reg;
                    cur_next  = link_rdata;
                    idx_next  = idx_inc;
                end
            end

            S_REM_FREE:
            begin
                link_we     = 1'b1;
                link_waddr  = cur_reg;
                link_wdata  = free_reg;
                free_next   = cur_reg;
                length_next = length_reg - 1'b1;
                done_next   = 1'b1;
                status_next = ST_OK;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            req_reg    <= REQ_ADD_FRONT;
            card_reg   <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            free_reg   <= '0;
            fresh_reg  <= '0;
            length_reg <= '0;
            cur_reg    <= '0;
            prev_reg   <= '0;
            idx_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            req_reg    <= req_next;
            card_reg   <= card_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            free_reg   <= free_next;
            fresh_reg  <= fresh_next;
            length_reg <= length_next;
            cur_reg    <= cur_next;
            prev_reg   <= prev_next;
            idx_reg    <= idx_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    assign len_ext     = {{LEN_OUT_W{1'b0}}, length_reg};
    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign list_length = len_ext[LEN_OUT_W-1:0];

    a_len_le_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= fresh_reg)
        else $error("list length exceeds slots handed out");

    a_fresh_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= CAP_CNT)
        else $error("fresh slot count beyond capacity");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result shown while a transaction is in flight");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_FULL) |-> length_reg == CAP_CNT)
        else $error("full status on a list that is not full");

    a_len_moves_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (length_reg != $past(length_reg)) |-> done_reg)
        else $error("list length changed without a result");

endmodule

/* verif/tb_top.sv */
// tb_top: self-checking testbench for ordered_card_list_engine
// keeps a shadow copy of the card list and free list to predict every result
// depends on ocl_pkg and the engine rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ocl_pkg::*;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = 6;
    localparam int TAIL_WAIT = 80;

    localparam req_t REQ_UNUSED_LO = 3'd6;
    localparam req_t REQ_UNUSED_HI = 3'd7;

    typedef struct packed {
        status_t              status;
        logic [LEN_OUT_W-1:0] length;
    } list_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [REQ_W-1:0]     req_type;
    logic [3:0]           card_num;
    logic [1:0]           card_suit;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [LEN_OUT_W-1:0] list_length;

    card_t             shadow_card [CAPACITY];
    logic [SLOT_W-1:0] shadow_link [CAPACITY];
    logic [SLOT_W-1:0] shadow_head = '0;
    logic [SLOT_W-1:0] shadow_tail = '0;
    logic [SLOT_W-1:0] shadow_free = '0;
    int                shadow_fresh = 0;
    int                shadow_len = 0;

    list_result_t pending_results [$];
    list_result_t oldest_result;
    int           mismatch_count = 0;
    bit           no_idle = 1'b0;

    ordered_card_list_engine #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .card_num(card_num),
        .card_suit(card_suit),
        .done(done),
        .status(status),
        .list_length(list_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [SLOT_W-1:0] claim_node();
        logic [SLOT_W-1:0] slot;
        if (shadow_fresh > shadow_len)
        begin
            slot = shadow_free;
            shadow_free = shadow_link[slot];
        end
        else
        begin
            slot = SLOT_W'(shadow_fresh);
            shadow_fresh++;
        end
        return slot;
    endfunction

    function automatic void free_node(logic [SLOT_W-1:0] slot);
        shadow_link[slot] = shadow_free;
        shadow_free = slot;
    endfunction

    function automatic list_result_t predict_list_result(req_t req, logic [3:0] num,
                                                         logic [1:0] suit);
        list_result_t      res;
        card_t             card;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] prev;
        logic [SLOT_W-1:0] cur;
        int                i;
        int                pos;
        bit                hit;
        card = {num, suit};
        res.status = ST_MISS;
        hit = 1'b0;
        pos = 0;
        prev = '0;
        cur = shadow_head;
        case (req)
            REQ_ADD_FRONT, REQ_ADD_BACK:
            begin
                if (shadow_len >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    slot = claim_node();
                    shadow_card[slot] = card;
                    if (shadow_len == 0)
                    begin
                        shadow_link[slot] = '0;
                        shadow_head = slot;
                        shadow_tail = slot;
                    end
                    else if (req == REQ_ADD_FRONT)
                    begin
                        shadow_link[slot] = shadow_head;
                        shadow_head = slot;
                    end
                    else
                    begin
                        shadow_link[slot] = '0;
                        shadow_link[shadow_tail] = slot;
                        shadow_tail = slot;
                    end
                    shadow_len++;
                    res.status = ST_OK;
                end
            end
            REQ_FIND:
            begin
                for (i = 0; i < shadow_len && !hit; i++)
                begin
                    if (shadow_card[cur] == card)
                        hit = 1'b1;
                    else
                        cur = shadow_link[cur];
                end
                if (hit)
                    res.status = ST_OK;
            end
            REQ_POP_FRONT:
            begin
                if (shadow_len > 0)
                begin
                    slot = shadow_head;
                    shadow_head = shadow_link[slot];
                    free_node(slot);
                    shadow_len--;
                    res.status = ST_OK;
                end
            end
            REQ_REMOVE:
            begin
                for (i = 0; i < shadow_len && !hit; i++)
                begin
                    if (shadow_card[cur] == card)
                    begin
                        hit = 1'b1;
                        pos = i;
                    end
                    else
                    begin
                        prev = cur;
                        cur = shadow_link[cur];
                    end
                end
                if (hit)
                begin
                    if (pos == 0)
                        shadow_head = shadow_link[cur];
                    else
                        shadow_link[prev] = shadow_link[cur];
                    if (pos + 1 == shadow_len)
                        shadow_tail = prev;
                    free_node(cur);
                    shadow_len--;
                    res.status = ST_OK;
                end
            end
            REQ_CLEAR:
            begin
                shadow_head = '0;
                shadow_tail = '0;
                shadow_free = '0;
                shadow_fresh = 0;
                shadow_len = 0;
                res.status = ST_OK;
            end
            default:
                res.status = ST_MISS;
        endcase
        res.length = LEN_OUT_W'(shadow_len);
        return res;
    endfunction

    function automatic card_t listed_card(int idx);
        logic [SLOT_W-1:0] cur;
        int                i;
        cur = shadow_head;
        for (i = 0; i < idx; i++)
            cur = shadow_link[cur];
        return shadow_card[cur];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    task automatic flag_mismatch(string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // one transaction: wait out the gap, present it and hold until busy is low
    task automatic send_request(req_t req, logic [3:0] num, logic [1:0] suit);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        req_type = req;
        card_num = num;
        card_suit = suit;
        while (busy)
            @(negedge clk);
        pending_results.push_back(predict_list_result(req, num, suit));
        @(posedge clk);
    endtask

    task automatic wait_until_settled(int extra);
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
                flag_mismatch($sformatf("unexpected result status %0d length %0d",
                                        status, list_length));
            else
            begin
                oldest_result = pending_results.pop_front();
                if (status !== oldest_result.status)
                    flag_mismatch($sformatf("status %0d, wanted %0d",
                                            status, oldest_result.status));
                if (list_length !== oldest_result.length)
                    flag_mismatch($sformatf("list_length %0d, wanted %0d",
                                            list_length, oldest_result.length));
            end
        end
    end

    task automatic test_empty_list();
        send_request(REQ_POP_FRONT, 4'd0, 2'd0);
        send_request(REQ_FIND, 4'd0, 2'd0);
        send_request(REQ_REMOVE, 4'd15, 2'd3);
        send_request(REQ_UNUSED_LO, 4'd15, 2'd3);
        send_request(REQ_UNUSED_HI, 4'd0, 2'd0);
        send_request(REQ_CLEAR, 4'd0, 2'd0);
    endtask

    task automatic test_short_list();
        // add at back on an empty list becomes the head
        send_request(REQ_ADD_BACK, 4'd15, 2'd3);
        send_request(REQ_FIND, 4'd15, 2'd3);
        send_request(REQ_FIND, 4'd15, 2'd2);
        send_request(REQ_POP_FRONT, 4'd0, 2'd0);
        send_request(REQ_ADD_FRONT, 4'd0, 2'd0);
        send_request(REQ_REMOVE, 4'd0, 2'd0);
        send_request(REQ_ADD_BACK, 4'd5, 2'd1);
        send_request(REQ_ADD_BACK, 4'd9, 2'd2);
        send_request(REQ_ADD_FRONT, 4'd3, 2'd3);
        send_request(REQ_REMOVE, 4'd5, 2'd1);
        send_request(REQ_REMOVE, 4'd9, 2'd2);
        // tail must have moved back after removing the last card
        send_request(REQ_ADD_BACK, 4'd7, 2'd0);
        send_request(REQ_FIND, 4'd7, 2'd0);
        send_request(REQ_REMOVE, 4'd3, 2'd3);
        send_request(REQ_REMOVE, 4'd12, 2'd1);
        send_request(REQ_CLEAR, 4'd0, 2'd0);
    endtask

    task automatic test_full_list();
        int    k;
        card_t c;
        for (k = 0; k < CAPACITY; k++)
            send_request((k % 2) ? REQ_ADD_BACK : REQ_ADD_FRONT,
                         4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
        send_request(REQ_ADD_FRONT, 4'd15, 2'd3);
        send_request(REQ_ADD_BACK, 4'd0, 2'd0);
        c = listed_card(CAPACITY - 1);
        send_request(REQ_FIND, c[5:2], c[1:0]);
        send_request(REQ_REMOVE, c[5:2], c[1:0]);
        for (k = 0; k < 20; k++)
            send_request(REQ_FIND, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
        wait_until_settled(4);
        while (shadow_len > 0)
        begin
            if ($urandom_range(0, 1))
                send_request(REQ_POP_FRONT, 4'($urandom_range(0, 15)),
                             2'($urandom_range(0, 3)));
            else
            begin
                c = listed_card($urandom_range(0, shadow_len - 1));
                send_request(REQ_REMOVE, c[5:2], c[1:0]);
            end
        end
        send_request(REQ_POP_FRONT, 4'd0, 2'd0);
    endtask

    task automatic test_random_traffic(int count, int add_pct);
        int         n;
        int         r;
        req_t       req;
        logic [3:0] num;
        logic [1:0] suit;
        card_t      c;
        for (n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                no_idle = ($urandom_range(0, 99) < 30);
            if ($urandom_range(0, 199) == 0)
                wait_until_settled(4);
            num = 4'($urandom_range(0, 15));
            suit = 2'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            if (r < add_pct)
            begin
                req = $urandom_range(0, 1) ? REQ_ADD_FRONT : REQ_ADD_BACK;
                // a narrow rank pool gives duplicate cards
                if ($urandom_range(0, 1))
                    num = 4'($urandom_range(0, 3));
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    req = REQ_FIND;
                else if (r < 60)
                    req = REQ_POP_FRONT;
                else if (r < 97)
                    req = REQ_REMOVE;
                else if (r < 98)
                    req = REQ_CLEAR;
                else
                    req = req_t'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
                if ((req == REQ_FIND || req == REQ_REMOVE) && shadow_len > 0
                    && $urandom_range(0, 99) < 70)
                begin
                    c = listed_card($urandom_range(0, shadow_len - 1));
                    num = c[5:2];
                    suit = c[1:0];
                end
            end
            send_request(req, num, suit);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_ADD_FRONT;
        card_num = '0;
        card_suit = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_short_list();
        wait_until_settled(4);
        test_full_list();
        test_random_traffic(600, 65);
        wait_until_settled(4);
        test_random_traffic(700, 45);
        test_random_traffic(500, 30);

        wait_until_settled(TAIL_WAIT);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/ocl_pkg.sv
rtl/ocl_node_ram.sv
rtl/ordered_card_list_engine.sv
verif/tb_top.sv
